/* rtl/cbfs_pkg.sv */
// cbfs_pkg: shared codes and fixed widths of the cubic bezier flight stepper
// used by the stepper top level and its port checker; no dependencies
`default_nettype none

package cbfs_pkg;

  // request codes
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_START  = 2'd1;
  localparam logic [1:0] REQ_CANCEL = 2'd2;

  // result status codes
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_MOVING  = 2'd1;
  localparam logic [1:0] ST_HANDOFF = 2'd2;

  // configuration register indexes
  localparam int CFG_INDEX_WIDTH = 3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CTRL0     = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CTRL1     = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CTRL2     = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CTRL3     = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RATE      = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WINDOW_Z  = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_THRESHOLD = 3'd6;

  // fixed field widths and fraction bits
  localparam int REQ_WIDTH     = 2;
  localparam int STATUS_WIDTH  = 2;
  localparam int ELAPSED_WIDTH = 16;
  localparam int ELAPSED_FRAC  = 16;
  localparam int RATE_WIDTH    = 24;
  localparam int RATE_FRAC     = 16;
  localparam int WIN_WIDTH     = 19;
  localparam int VEL_WIDTH     = 24;

  // reset values: rate of 1.0 per second, z window of 0.01 m
  localparam logic [RATE_WIDTH-1:0] RATE_RESET = 24'd65536;
  localparam logic [WIN_WIDTH-1:0]  WIN_RESET  = 19'd41;

endpackage

`default_nettype wire

/* rtl/cubic_bezier_flight_stepper.sv */
// cubic_bezier_flight_stepper: steps t along a cubic bezier and reports position/velocity
// start, cancel and idle ticks go straight to the result register; a moving tick steps t,
// forms the weights and sums the position; a tick that hands off also forms velocity
// one item at a time: the next input transfer can be taken the cycle after the result is
// loaded; all products go through the single shared 2-operand multiplier
// sync active-high reset: not flying, t = 0, config registers to their defaults; uses cbfs_pkg
`default_nettype none

module cubic_bezier_flight_stepper
  import cbfs_pkg::*;
#(
  parameter int COORD_WIDTH     = 20,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  wire                                clk,
  input  wire                                rst,
  // input channel
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  [REQ_WIDTH-1:0]               req_type,
  input  wire  [ELAPSED_WIDTH-1:0]           elapsed,
  // result channel
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [STATUS_WIDTH-1:0]            status,
  output logic signed [COORD_WIDTH-1:0]      pos_x,
  output logic signed [COORD_WIDTH-1:0]      pos_y,
  output logic signed [COORD_WIDTH-1:0]      pos_z,
  output logic signed [VEL_WIDTH-1:0]        vel_x,
  output logic signed [VEL_WIDTH-1:0]        vel_y,
  output logic signed [VEL_WIDTH-1:0]        vel_z,
  output logic [PARAM_FRAC_BITS:0]           param_now,
  // configuration write port
  input  wire                                cfg_wr_en,
  input  wire  [CFG_INDEX_WIDTH-1:0]         cfg_index,
  input  wire  [3*COORD_WIDTH-1:0]           cfg_wr_data
);

  // ---------------------------------------------------------------------------
  // widths
  // ---------------------------------------------------------------------------
  localparam int CW   = COORD_WIDTH;
  localparam int F    = PARAM_FRAC_BITS;
  localparam int PW   = F + 1;                 // t, u and weights before scaling
  localparam int CDW  = 3 * CW;                // packed control point
  localparam int WW   = F + 4;                 // signed weight / coefficient
  localparam int DQW  = CW + 4;                // derivative in coordinate units
  // multiplier operand width covers weights, coordinates, dq and the rate
  localparam int MW_A = (WW > DQW) ? WW : DQW;
  localparam int MW   = (MW_A > RATE_WIDTH + 1) ? MW_A : RATE_WIDTH + 1;
  localparam int PRODW = 2 * MW;
  localparam int AW   = PRODW + 2;             // accumulator over four products
  localparam int UW   = 2 * F + 2;             // rounding of a Q1.F x Q1.F product
  // parameter step: bits of elapsed * rate that land at or above t's lsb
  localparam int DT_LO = ELAPSED_FRAC + RATE_FRAC - F;
  localparam int DT_HI = ELAPSED_WIDTH + RATE_WIDTH - 1;
  localparam int SW    = DT_HI - DT_LO + 2;
  localparam int DZW   = (CW + 2 > WIN_WIDTH + 2) ? CW + 2 : WIN_WIDTH + 2;

  localparam logic [PW-1:0] ONE       = PW'(longint'(1) << F);
  localparam logic [PW-1:0] TD_MAX    = PW'((999 * (longint'(1) << F) + 500) / 1000);
  localparam logic [PW-1:0] THR_RESET = PW'((995 * (longint'(1) << F) + 500) / 1000);
  localparam logic [UW-1:0] RED_HALF  = UW'(longint'(1) << (F - 1));
  localparam logic signed [AW-1:0] ACC_HALF = AW'(longint'(1) << (F - 1));
  localparam logic signed [AW-1:0] POS_MAX  = AW'((longint'(1) << (CW - 1)) - 1);
  localparam logic signed [AW-1:0] POS_MIN  = -POS_MAX - AW'(1);
  localparam logic signed [PRODW-1:0] VEL_HALF = PRODW'(longint'(1) << (RATE_FRAC - 1));
  localparam logic signed [PRODW-1:0] VEL_MAX  =
    PRODW'((longint'(1) << (VEL_WIDTH - 1)) - 1);
  localparam logic signed [PRODW-1:0] VEL_MIN  = -VEL_MAX - PRODW'(1);

  // ---------------------------------------------------------------------------
  // sequencer state and product tags
  // ---------------------------------------------------------------------------
  typedef enum logic [4:0] {
    S_IDLE, S_DT, S_TWAIT, S_TU, S_UU, S_TT, S_W0, S_W1, S_W2, S_W3,
    S_MAC, S_PDRAIN, S_DZ, S_NEAR, S_C0, S_C1, S_C2, S_CWAIT, S_COEF,
    S_DDRAIN, S_VEL, S_VDRAIN, S_OUT
  } state_t;

  // what the product register holds, handled in the cycle after issue
  typedef enum logic [3:0] {
    OP_NONE, OP_DT, OP_U2, OP_T2, OP_W0, OP_W1, OP_W2, OP_W3,
    OP_C0, OP_C1, OP_C2, OP_POS, OP_DER, OP_VEL
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] kk;
    logic [1:0] ax;
  } tag_t;

  state_t state;
  tag_t   tag;
  logic [1:0] kk;          // control point index in the mac loop
  logic [1:0] ax;          // axis index
  logic       der_phase;   // mac loop runs the derivative coefficients
  logic       in_flight;
  logic [PW-1:0] curve_param;
  logic [STATUS_WIDTH-1:0] status_r;

  // configuration registers
  logic [CDW-1:0]        ctrl_point [4];
  logic [RATE_WIDTH-1:0] param_rate;
  logic [WIN_WIDTH-1:0]  end_window_z;
  logic [PW-1:0]         end_param_threshold;

  // datapath registers
  logic signed [PRODW-1:0] prod;
  logic [ELAPSED_WIDTH-1:0] elapsed_r;
  logic [PW-1:0] tr, u, td, ud, u2, t2;
  logic signed [WW-1:0] wt [4];
  logic signed [WW-1:0] c0, c1, c2;
  logic signed [AW-1:0] acc;
  logic signed [CW-1:0] pos_r [3];
  logic signed [DQW-1:0] dq_r [3];
  logic signed [VEL_WIDTH-1:0] vel_r [3];
  logic signed [DZW-1:0] dz;
  logic thr_hit;

  // combinational
  op_t op_next;
  logic signed [MW-1:0] opa, opb;
  logic signed [CW-1:0] coord_sel;
  logic signed [CW-1:0] end_z;
  logic [SW-1:0]  dt_sum;
  logic [PW-1:0]  t_clamp;
  logic [UW-1:0]  red_rnd;
  logic [PW-1:0]  red;
  logic [WW-1:0]  red3, red6;
  logic signed [AW-1:0] mac_sum, mac_sh;
  logic signed [CW-1:0] pos_sat;
  logic signed [PRODW-1:0] vel_sum, vel_sh;
  logic signed [VEL_WIDTH-1:0] vel_sat;
  logic signed [DZW-1:0] win_s;
  logic near_end;

  assign in_ready = (state == S_IDLE) && !rst;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) ctrl_point[i] <= '0;
      param_rate          <= RATE_RESET;
      end_window_z        <= WIN_RESET;
      end_param_threshold <= THR_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CTRL0:     ctrl_point[0] <= cfg_wr_data;
        REG_CTRL1:     ctrl_point[1] <= cfg_wr_data;
        REG_CTRL2:     ctrl_point[2] <= cfg_wr_data;
        REG_CTRL3:     ctrl_point[3] <= cfg_wr_data;
        REG_RATE:      param_rate <= cfg_wr_data[RATE_WIDTH-1:0];
        REG_WINDOW_Z:  end_window_z <= cfg_wr_data[WIN_WIDTH-1:0];
        REG_THRESHOLD: end_param_threshold <= cfg_wr_data[PW-1:0];
        default: ;  // index past the register list is dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // shared multiplier operand select
  // ---------------------------------------------------------------------------
  assign coord_sel = $signed(ctrl_point[kk][ax*CW +: CW]);
  assign end_z     = $signed(ctrl_point[3][2*CW +: CW]);

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (state)
      S_DT: begin
        opa = MW'(elapsed_r);
        opb = MW'(param_rate);
      end
      S_UU: begin opa = MW'(u);  opb = MW'(u);  end
      S_TT: begin opa = MW'(tr); opb = MW'(tr); end
      S_W0: begin opa = MW'(u2); opb = MW'(u);  end
      S_W1: begin opa = MW'(u2); opb = MW'(tr); end
      S_W2: begin opa = MW'(t2); opb = MW'(u);  end
      S_W3: begin opa = MW'(t2); opb = MW'(tr); end
      S_C0: begin opa = MW'(ud); opb = MW'(ud); end
      S_C1: begin opa = MW'(ud); opb = MW'(td); end
      S_C2: begin opa = MW'(td); opb = MW'(td); end
      S_MAC: begin
        opa = MW'(wt[kk]);
        opb = MW'(coord_sel);
      end
      S_VEL: begin
        opa = MW'(dq_r[ax]);
        opb = MW'(param_rate);
      end
      default: ;
    endcase
  end

  // tag issued along with the operands of this cycle
  always_comb begin
    unique case (state)
      S_DT:    op_next = OP_DT;
      S_UU:    op_next = OP_U2;
      S_TT:    op_next = OP_T2;
      S_W0:    op_next = OP_W0;
      S_W1:    op_next = OP_W1;
      S_W2:    op_next = OP_W2;
      S_W3:    op_next = OP_W3;
      S_C0:    op_next = OP_C0;
      S_C1:    op_next = OP_C1;
      S_C2:    op_next = OP_C2;
      S_MAC:   op_next = der_phase ? OP_DER : OP_POS;
      S_VEL:   op_next = OP_VEL;
      default: op_next = OP_NONE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // product post-processing
  // ---------------------------------------------------------------------------
  // parameter step, clamped at one
  assign dt_sum  = SW'(curve_param) + SW'(prod[DT_HI:DT_LO]);
  assign t_clamp = (dt_sum > SW'(ONE)) ? ONE : dt_sum[PW-1:0];

  // Q1.F x Q1.F back to Q1.F with half-up rounding
  assign red_rnd = prod[UW-1:0] + RED_HALF;
  assign red     = red_rnd[2*F:F];
  assign red3    = WW'(red) + (WW'(red) << 1);
  assign red6    = red3 << 1;

  // mac: the first product of an axis brings the rounding half along
  assign mac_sum = (tag.kk == 2'd0) ? AW'(prod) + ACC_HALF : acc + AW'(prod);
  assign mac_sh  = mac_sum >>> F;
  assign pos_sat = (mac_sh > POS_MAX) ? POS_MAX[CW-1:0] :
                   (mac_sh < POS_MIN) ? POS_MIN[CW-1:0] : mac_sh[CW-1:0];

  // velocity: derivative times rate, rounded and saturated
  assign vel_sum = prod + VEL_HALF;
  assign vel_sh  = vel_sum >>> RATE_FRAC;
  assign vel_sat = (vel_sh > VEL_MAX) ? VEL_MAX[VEL_WIDTH-1:0] :
                   (vel_sh < VEL_MIN) ? VEL_MIN[VEL_WIDTH-1:0] : vel_sh[VEL_WIDTH-1:0];

  // near-end test: |dz| < window, or t at or above the threshold
  assign win_s    = DZW'(end_window_z);
  assign near_end = ((dz < win_s) && (dz > -win_s)) || thr_hit;

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    prod <= opa * opb;

    if (state == S_IDLE && in_valid) begin
      elapsed_r <= elapsed;
    end
    if (state == S_TU) begin
      u       <= ONE - tr;
      td      <= (tr < TD_MAX) ? tr : TD_MAX;
      thr_hit <= (tr >= end_param_threshold);
    end
    if (state == S_UU) begin
      ud <= ONE - td;
    end
    if (state == S_DZ) begin
      dz <= DZW'(end_z) - DZW'(pos_r[2]);
    end
    // derivative weights folded onto the points: -c0, c0-c1, c1-c2, c2
    if (state == S_COEF) begin
      wt[0] <= -c0;
      wt[1] <= c0 - c1;
      wt[2] <= c1 - c2;
      wt[3] <= c2;
    end

    unique case (tag.op)
      OP_DT: tr <= t_clamp;
      OP_U2: u2 <= red;
      OP_T2: t2 <= red;
      OP_W0: wt[0] <= $signed(WW'(red));
      OP_W1: wt[1] <= $signed(red3);
      OP_W2: wt[2] <= $signed(red3);
      OP_W3: wt[3] <= $signed(WW'(red));
      OP_C0: c0 <= $signed(red3);
      OP_C1: c1 <= $signed(red6);
      OP_C2: c2 <= $signed(red3);
      OP_POS: begin
        acc <= mac_sum;
        if (tag.kk == 2'd3) pos_r[tag.ax] <= pos_sat;
      end
      OP_DER: begin
        acc <= mac_sum;
        if (tag.kk == 2'd3) dq_r[tag.ax] <= mac_sh[DQW-1:0];
      end
      OP_VEL: vel_r[tag.ax] <= vel_sat;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer, flight state and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      tag         <= '{op: OP_NONE, kk: 2'd0, ax: 2'd0};
      kk          <= 2'd0;
      ax          <= 2'd0;
      der_phase   <= 1'b0;
      in_flight   <= 1'b0;
      curve_param <= '0;
      status_r    <= ST_IDLE;
      out_valid   <= 1'b0;
    end else begin
      tag.op <= op_next;
      // a result leaves on its transfer unless the next one is loaded now
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;

      // new t is committed as soon as the step product comes back
      if (tag.op == OP_DT) curve_param <= t_clamp;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            status_r <= ST_IDLE;
            unique case (req_type)
              REQ_START: begin
                curve_param <= '0;
                in_flight   <= 1'b1;
                state       <= S_OUT;
              end
              REQ_CANCEL: begin
                in_flight <= 1'b0;
                state     <= S_OUT;
              end
              REQ_TICK: begin
                state <= in_flight ? S_DT : S_OUT;
              end
              default: state <= S_OUT;  // unused code acts as an idle tick
            endcase
          end
        end
        S_DT:    state <= S_TWAIT;
        S_TWAIT: state <= S_TU;
        S_TU:    state <= S_UU;
        S_UU:    state <= S_TT;
        S_TT:    state <= S_W0;
        S_W0:    state <= S_W1;
        S_W1:    state <= S_W2;
        S_W2:    state <= S_W3;
        S_W3: begin
          kk        <= 2'd0;
          ax        <= 2'd0;
          der_phase <= 1'b0;
          state     <= S_MAC;
        end
        // four weighted points per axis, three axes
        S_MAC: begin
          tag.kk <= kk;
          tag.ax <= ax;
          if (kk == 2'd3) begin
            kk <= 2'd0;
            if (ax == 2'd2) begin
              ax    <= 2'd0;
              state <= der_phase ? S_DDRAIN : S_PDRAIN;
            end else begin
              ax <= ax + 2'd1;
            end
          end else begin
            kk <= kk + 2'd1;
          end
        end
        S_PDRAIN: state <= S_DZ;
        S_DZ:     state <= S_NEAR;
        S_NEAR: begin
          if (near_end) begin
            state <= S_C0;
          end else begin
            status_r <= ST_MOVING;
            state    <= S_OUT;
          end
        end
        S_C0:    state <= S_C1;
        S_C1:    state <= S_C2;
        S_C2:    state <= S_CWAIT;
        S_CWAIT: state <= S_COEF;
        S_COEF: begin
          kk        <= 2'd0;
          ax        <= 2'd0;
          der_phase <= 1'b1;
          state     <= S_MAC;
        end
        S_DDRAIN: state <= S_VEL;
        S_VEL: begin
          tag.ax <= ax;
          if (ax == 2'd2) begin
            ax    <= 2'd0;
            state <= S_VDRAIN;
          end else begin
            ax <= ax + 2'd1;
          end
        end
        S_VDRAIN: begin
          status_r  <= ST_HANDOFF;
          in_flight <= 1'b0;
          state     <= S_OUT;
        end
        // load the result once the previous one has been transferred
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= status_r;
            pos_x     <= (status_r != ST_IDLE) ? pos_r[0] : '0;
            pos_y     <= (status_r != ST_IDLE) ? pos_r[1] : '0;
            pos_z     <= (status_r != ST_IDLE) ? pos_r[2] : '0;
            vel_x     <= (status_r == ST_HANDOFF) ? vel_r[0] : '0;
            vel_y     <= (status_r == ST_HANDOFF) ? vel_r[1] : '0;
            vel_z     <= (status_r == ST_HANDOFF) ? vel_r[2] : '0;
            param_now <= curve_param;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/cbfs_checker.sv */
// cbfs_checker: port-level checks on the cubic bezier flight stepper, bound to the top
// depends on cbfs_pkg for status codes and fixed widths
`default_nettype none

module cbfs_checker
  import cbfs_pkg::*;
#(
  parameter int COORD_WIDTH     = 20,
  parameter int PARAM_FRAC_BITS = 16
) (
  input wire                            clk,
  input wire                            rst,
  input wire                            in_valid,
  input wire                            in_ready,
  input wire                            out_valid,
  input wire                            out_ready,
  input wire [STATUS_WIDTH-1:0]         status,
  input wire signed [COORD_WIDTH-1:0]   pos_x,
  input wire signed [COORD_WIDTH-1:0]   pos_y,
  input wire signed [COORD_WIDTH-1:0]   pos_z,
  input wire signed [VEL_WIDTH-1:0]     vel_x,
  input wire signed [VEL_WIDTH-1:0]     vel_y,
  input wire signed [VEL_WIDTH-1:0]     vel_z,
  input wire [PARAM_FRAC_BITS:0]        param_now
);

  localparam logic [PARAM_FRAC_BITS:0] PONE = (PARAM_FRAC_BITS + 1)'(1) << PARAM_FRAC_BITS;

  // a waiting result keeps its status, curve parameter, z position and z velocity
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(param_now)
      && $stable(pos_z) && $stable(vel_z))
    else $error("result changed while stalled");

  // velocity is only reported on handoff
  a_vel_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_HANDOFF |-> vel_x == '0 && vel_y == '0 && vel_z == '0)
    else $error("velocity nonzero without handoff");

  // idle results carry no position
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_IDLE |-> pos_x == '0 && pos_y == '0 && pos_z == '0)
    else $error("position nonzero on idle result");

  // curve parameter is clamped at one
  a_param_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> param_now <= PONE)
    else $error("curve parameter above one");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

endmodule

bind cubic_bezier_flight_stepper cbfs_checker #(
  .COORD_WIDTH    (COORD_WIDTH),
  .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
) u_cbfs_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .status   (status),
  .pos_x    (pos_x),
  .pos_y    (pos_y),
  .pos_z    (pos_z),
  .vel_x    (vel_x),
  .vel_y    (vel_y),
  .vel_z    (vel_z),
  .param_now(param_now)
);

`default_nettype wire
